FILE: sv/ctc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctc_pkg
// shared types, constants and helpers of the contingency table counter
// ----------------------------------------------------------------------------
package ctc_pkg;

	localparam int TABLE_CELLS = 4096;
	localparam int CELL_AW     = $clog2(TABLE_CELLS);
	localparam int WIDE_AW     = 16;
	localparam int COUNT_W     = 20;
	localparam int MAX_CARD    = 16;
	localparam int CARD_W      = 5;
	localparam int VAL_W       = 4;
	localparam int CFGS_W      = 13;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 5;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// action codes on the input port
	localparam logic [1:0] ACT_CLEAR = 2'd0;
	localparam logic [1:0] ACT_COUNT = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CHILD_LEVELS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PARENTS_USED = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CARD_FIRST   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CARD_SECOND  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CARD_THIRD   = 3'd4;

	typedef enum logic [1:0] {
		OP_CLEAR,
		OP_COUNT,
		OP_READ,
		OP_REJECT
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_SAT   = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		BK_SWEEP,
		BK_IDLE,
		BK_LOOK,
		BK_RESULT
	} back_state_t;

	typedef struct packed {
		logic [CARD_W-1:0] child_levels;
		logic [1:0]        parents_used;
		logic [CARD_W-1:0] card_first;
		logic [CARD_W-1:0] card_second;
		logic [CARD_W-1:0] card_third;
	} cfg_t;

	// one classified item on its way from front to back
	typedef struct packed {
		op_t               op;
		logic              bad;
		logic [CELL_AW-1:0] addr;
		logic [CELL_AW-1:0] row;
		logic [CFGS_W-1:0] configs;
	} entry_t;

	// zero acts as one, anything above the maximum acts as the maximum
	function automatic logic [CARD_W-1:0] eff_card(input logic [CARD_W-1:0] c);
		logic [CARD_W-1:0] r;
		r = c;
		if (c == '0)
			r = CARD_W'(1);
		else if (c > CARD_W'(MAX_CARD))
			r = CARD_W'(MAX_CARD);
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: sv/ctc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctc_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module ctc_ram #(
	parameter int WIDTH = 20,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

FILE: sv/ctc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctc_front
// three stage classifier: folds parent values into a configuration index,
// forms the cell address and flags out-of-range items
// ----------------------------------------------------------------------------
module ctc_front (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire ctc_pkg::cfg_t                   cfg,
	input  wire logic                            take,
	input  wire logic [1:0]                      action,
	input  wire logic [ctc_pkg::VAL_W-1:0]       child_val,
	input  wire logic [ctc_pkg::VAL_W-1:0]       first_parent_value,
	input  wire logic [ctc_pkg::VAL_W-1:0]       second_parent_value,
	input  wire logic [ctc_pkg::VAL_W-1:0]       third_parent_value,
	input  wire logic [ctc_pkg::CELL_AW-1:0]     read_config,
	input  wire logic [ctc_pkg::VAL_W-1:0]       read_child,
	output      logic                            stall,
	output      ctc_pkg::entry_t                 entry,
	output      logic                            entry_valid,
	input  wire logic                            entry_ready
);
	import ctc_pkg::*;

	logic [CARD_W-1:0] cc, c1u, c2u, c3u;
	logic [VAL_W-1:0]  v1u, v2u, v3u;
	logic              pbad;
	op_t               op_in;
	logic [8:0]        a_w;
	logic [WIDE_AW-1:0] rcell_w;
	logic [CFGS_W-1:0] cfg_w;
	logic [WIDE_AW-1:0] cell_w;
	logic              adv1, adv2, adv3;
	entry_t            entry_d;

	// stage 1
	logic               v_s1;
	op_t                op_s1;
	logic [VAL_W-1:0]   cv_s1, v3_s1;
	logic [CELL_AW-1:0] rc_s1;
	logic [7:0]         a_s1;
	logic [8:0]         p12_s1;
	logic               pbad_s1, rbad_s1;
	logic [WIDE_AW-1:0] rcell_s1;

	// stage 2
	logic               v_s2;
	op_t                op_s2;
	logic [VAL_W-1:0]   cv_s2;
	logic [CELL_AW-1:0] rc_s2, cfg_s2, rcell_s2;
	logic [CFGS_W-1:0]  configs_s2;
	logic               pbad_s2, rbad_s2;

	// stage 3
	logic               v_s3;
	entry_t             entry_s3;

	// unused parents fold as cardinality one, value zero
	always_comb begin
		cc   = eff_card(cfg.child_levels);
		c1u  = (cfg.parents_used >= 2'd1) ? eff_card(cfg.card_first) : CARD_W'(1);
		c2u  = (cfg.parents_used >= 2'd2) ? eff_card(cfg.card_second) : CARD_W'(1);
		c3u  = (cfg.parents_used == 2'd3) ? eff_card(cfg.card_third) : CARD_W'(1);
		v1u  = (cfg.parents_used >= 2'd1) ? first_parent_value : '0;
		v2u  = (cfg.parents_used >= 2'd2) ? second_parent_value : '0;
		v3u  = (cfg.parents_used == 2'd3) ? third_parent_value : '0;
		pbad = ({1'b0, v1u} >= c1u) || ({1'b0, v2u} >= c2u) || ({1'b0, v3u} >= c3u);
		case (action)
			ACT_CLEAR: op_in = OP_CLEAR;
			ACT_COUNT: op_in = OP_COUNT;
			ACT_READ:  op_in = OP_READ;
			default:   op_in = OP_REJECT;
		endcase
		a_w     = 9'(v1u * c2u) + 9'(v2u);
		rcell_w = WIDE_AW'(read_config * cc) + WIDE_AW'(read_child);
	end

	assign adv3  = !v_s3 || entry_ready;
	assign adv2  = !v_s2 || adv3;
	assign adv1  = !v_s1 || adv2;
	assign stall = !adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1)
				v_s1 <= take;
			if (adv2)
				v_s2 <= v_s1;
			if (adv3)
				v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			op_s1    <= op_in;
			cv_s1    <= child_val;
			v3_s1    <= v3u;
			rc_s1    <= read_config;
			a_s1     <= a_w[7:0];
			p12_s1   <= 9'(c1u * c2u);
			pbad_s1  <= pbad;
			rbad_s1  <= {1'b0, read_child} >= cc;
			rcell_s1 <= rcell_w;
		end
	end

	assign cfg_w = CFGS_W'(a_s1 * c3u) + CFGS_W'(v3_s1);

	always_ff @(posedge clk) begin
		if (adv2) begin
			op_s2      <= op_s1;
			cv_s2      <= cv_s1;
			rc_s2      <= rc_s1;
			cfg_s2     <= cfg_w[CELL_AW-1:0];
			configs_s2 <= CFGS_W'(p12_s1 * c3u);
			pbad_s2    <= pbad_s1;
			rbad_s2    <= rbad_s1 || (rcell_s1 >= WIDE_AW'(TABLE_CELLS));
			rcell_s2   <= rcell_s1[CELL_AW-1:0];
		end
	end

	always_comb begin
		cell_w          = WIDE_AW'(cfg_s2 * cc) + WIDE_AW'(cv_s2);
		entry_d.op      = op_s2;
		entry_d.configs = configs_s2;
		entry_d.addr    = cell_w[CELL_AW-1:0];
		entry_d.row     = cfg_s2;
		entry_d.bad     = 1'b0;
		case (op_s2)
			OP_COUNT: begin
				entry_d.bad = pbad_s2 || ({1'b0, cv_s2} >= cc)
					|| (cell_w >= WIDE_AW'(TABLE_CELLS));
			end
			OP_READ: begin
				entry_d.bad  = rbad_s2 || (CFGS_W'(rc_s2) >= configs_s2);
				entry_d.addr = rcell_s2;
				entry_d.row  = rc_s2;
			end
			default: begin
				entry_d.bad = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv3)
			entry_s3 <= entry_d;
	end

	assign entry       = entry_s3;
	assign entry_valid = v_s3;

endmodule
`default_nettype wire

FILE: sv/ctc_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctc_queue
// short queue of classified items between front and back
// ----------------------------------------------------------------------------
module ctc_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire ctc_pkg::entry_t wr_entry,
	output      logic            full,
	input  wire logic            pop,
	output      ctc_pkg::entry_t head,
	output      logic            empty
);
	import ctc_pkg::*;

	entry_t              slot_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_AW:0]   fill_q;
	logic                do_push, do_pop;

	assign full    = fill_q == (QUEUE_AW+1)'(QUEUE_DEPTH);
	assign empty   = fill_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				fill_q <= fill_q + 1'b1;
			else if (do_pop && !do_push)
				fill_q <= fill_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= wr_entry;
	end

endmodule
`default_nettype wire

FILE: sv/ctc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctc_back
// carries out clear, count and read on the two count stores and holds the
// result register
// ----------------------------------------------------------------------------
module ctc_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          q_empty,
	input  wire ctc_pkg::entry_t               q_head,
	output      logic                          q_pop,
	output      logic                          init_busy,
	input  wire logic                          pop,
	output      logic                          empty,
	output      logic [ctc_pkg::COUNT_W-1:0]   cell_count,
	output      logic [ctc_pkg::COUNT_W-1:0]   row_total,
	output      logic [ctc_pkg::CFGS_W-1:0]    parent_configs,
	output      logic [1:0]                    status
);
	import ctc_pkg::*;

	back_state_t        state_q, state_d;
	logic               init_q;
	logic [CELL_AW-1:0] sweep_q;
	op_t                op_q;
	logic [CELL_AW-1:0] cell_q, row_q;
	logic [CFGS_W-1:0]  cfgs_q;
	logic [COUNT_W-1:0] res_cnt_q, res_tot_q;
	status_t            res_stat_q;

	logic               out_valid_q;
	logic [COUNT_W-1:0] out_cnt_q, out_tot_q;
	logic [CFGS_W-1:0]  out_cfgs_q;
	status_t            out_stat_q;

	logic               we;
	logic [CELL_AW-1:0] waddr_c, waddr_r;
	logic [COUNT_W-1:0] wd_c, wd_r, rd_c, rd_r, new_c, new_r;
	logic               hit_c, hit_r, out_free, out_load, sweep_last;

	ctc_ram #(.WIDTH(COUNT_W), .DEPTH(TABLE_CELLS)) u_cell_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr_c),
		.wdata (wd_c),
		.raddr (q_head.addr),
		.rdata (rd_c)
	);

	ctc_ram #(.WIDTH(COUNT_W), .DEPTH(TABLE_CELLS)) u_row_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr_r),
		.wdata (wd_r),
		.raddr (q_head.row),
		.rdata (rd_r)
	);

	// saturating increments
	assign hit_c = rd_c == COUNT_MAX;
	assign hit_r = rd_r == COUNT_MAX;
	assign new_c = hit_c ? rd_c : rd_c + 1'b1;
	assign new_r = hit_r ? rd_r : rd_r + 1'b1;

	assign out_free   = !out_valid_q || pop;
	assign out_load   = (state_q == BK_RESULT) && out_free;
	assign sweep_last = sweep_q == CELL_AW'(TABLE_CELLS - 1);
	assign init_busy  = init_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= BK_SWEEP;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		we      = 1'b0;
		waddr_c = sweep_q;
		waddr_r = sweep_q;
		wd_c    = '0;
		wd_r    = '0;
		case (state_q)
			BK_SWEEP: begin
				we = 1'b1;
				if (sweep_last)
					state_d = init_q ? BK_IDLE : BK_RESULT;
			end
			BK_IDLE: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					case (q_head.op)
						OP_CLEAR: state_d = BK_SWEEP;
						OP_COUNT, OP_READ: state_d = q_head.bad ? BK_RESULT : BK_LOOK;
						default: state_d = BK_RESULT;
					endcase
				end
			end
			BK_LOOK: begin
				if (op_q == OP_COUNT) begin
					we      = 1'b1;
					waddr_c = cell_q;
					waddr_r = row_q;
					wd_c    = new_c;
					wd_r    = new_r;
				end
				state_d = BK_RESULT;
			end
			BK_RESULT: begin
				if (out_free)
					state_d = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q  <= 1'b1;
			sweep_q <= '0;
		end else if (state_q == BK_SWEEP) begin
			sweep_q <= sweep_q + 1'b1;
			if (sweep_last)
				init_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			op_q      <= q_head.op;
			cell_q    <= q_head.addr;
			row_q     <= q_head.row;
			cfgs_q    <= q_head.configs;
			res_cnt_q <= '0;
			res_tot_q <= '0;
			if (q_head.op == OP_CLEAR)
				res_stat_q <= ST_OK;
			else
				res_stat_q <= ST_RANGE;
		end else if (state_q == BK_LOOK) begin
			if (op_q == OP_COUNT) begin
				res_cnt_q  <= new_c;
				res_tot_q  <= new_r;
				res_stat_q <= (hit_c || hit_r) ? ST_SAT : ST_OK;
			end else begin
				res_cnt_q  <= rd_c;
				res_tot_q  <= rd_r;
				res_stat_q <= ST_OK;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (pop)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_cnt_q  <= res_cnt_q;
			out_tot_q  <= res_tot_q;
			out_cfgs_q <= cfgs_q;
			out_stat_q <= res_stat_q;
		end
	end

	assign empty          = !out_valid_q;
	assign cell_count     = out_cnt_q;
	assign row_total      = out_tot_q;
	assign parent_configs = out_cfgs_q;
	assign status         = out_stat_q;

endmodule
`default_nettype wire

FILE: sv/contingency_table_counter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// contingency_table_counter
// counts (parent configuration, child value) pairs in a table of saturating
// cell counts with a per-configuration row total
// ----------------------------------------------------------------------------
//
// channel    direction  handshake              payload
// ---------  ---------  ---------------------  ----------------------------------
// items      in         push / full            action, child and parent values,
//                                              read_config, read_child
// results    out        pop / empty            cell_count, row_total,
//                                              parent_configs, status
// config     in         cfg_we                 cfg_idx, cfg_data
//
// an item passes a three stage front, then the short queue, then the back;
// a count or read takes the back through queue pop, store read and result,
// and the back pops no further item until that result is loaded for transfer
// a clear sweeps both stores one entry a cycle, then reports its result
// after reset the same sweep runs over all 4096 entries with full held high
// the front fills the queue while the back works or the result waits to be
// taken; full rises when front stages and queue are all occupied
//
module contingency_table_counter (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// item transfer
	input  wire logic                              push,
	output      logic                              full,
	input  wire logic [1:0]                        action,
	input  wire logic [ctc_pkg::VAL_W-1:0]         child_val,
	input  wire logic [ctc_pkg::VAL_W-1:0]         first_parent_value,
	input  wire logic [ctc_pkg::VAL_W-1:0]         second_parent_value,
	input  wire logic [ctc_pkg::VAL_W-1:0]         third_parent_value,
	input  wire logic [ctc_pkg::CELL_AW-1:0]       read_config,
	input  wire logic [ctc_pkg::VAL_W-1:0]         read_child,
	// result transfer
	output      logic                              empty,
	input  wire logic                              pop,
	output      logic [ctc_pkg::COUNT_W-1:0]       cell_count,
	output      logic [ctc_pkg::COUNT_W-1:0]       row_total,
	output      logic [ctc_pkg::CFGS_W-1:0]        parent_configs,
	output      logic [1:0]                        status,
	// configuration writes
	input  wire logic                              cfg_we,
	input  wire logic [ctc_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  wire logic [ctc_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import ctc_pkg::*;

	cfg_t   cfg_q;
	logic   front_stall, init_busy, take;
	entry_t fe_entry, q_head;
	logic   fe_valid, q_full, q_empty, q_pop;

	// configuration registers; the user must write them only while the block is idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.child_levels <= CARD_W'(2);
			cfg_q.parents_used <= 2'd0;
			cfg_q.card_first   <= CARD_W'(2);
			cfg_q.card_second  <= CARD_W'(2);
			cfg_q.card_third   <= CARD_W'(2);
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_CHILD_LEVELS: cfg_q.child_levels <= cfg_data;
				REG_PARENTS_USED: cfg_q.parents_used <= cfg_data[1:0];
				REG_CARD_FIRST:   cfg_q.card_first   <= cfg_data;
				REG_CARD_SECOND:  cfg_q.card_second  <= cfg_data;
				REG_CARD_THIRD:   cfg_q.card_third   <= cfg_data;
				default: ;
			endcase
		end
	end

	// no item transfer while the reset sweep clears the stores
	assign full = front_stall || init_busy;
	assign take = push && !full;

	ctc_front u_front (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg                 (cfg_q),
		.take                (take),
		.action              (action),
		.child_val           (child_val),
		.first_parent_value  (first_parent_value),
		.second_parent_value (second_parent_value),
		.third_parent_value  (third_parent_value),
		.read_config         (read_config),
		.read_child          (read_child),
		.stall               (front_stall),
		.entry               (fe_entry),
		.entry_valid         (fe_valid),
		.entry_ready         (!q_full)
	);

	// decouples classification from the store accesses
	ctc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (fe_valid),
		.wr_entry (fe_entry),
		.full     (q_full),
		.pop      (q_pop),
		.head     (q_head),
		.empty    (q_empty)
	);

	ctc_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_empty        (q_empty),
		.q_head         (q_head),
		.q_pop          (q_pop),
		.init_busy      (init_busy),
		.pop            (pop),
		.empty          (empty),
		.cell_count     (cell_count),
		.row_total      (row_total),
		.parent_configs (parent_configs),
		.status         (status)
	);

endmodule
`default_nettype wire

FILE: sv/ctc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctc_checker
// port-level checks on the result channel of the contingency table counter
// ----------------------------------------------------------------------------
module ctc_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            pop,
	input wire logic                            empty,
	input wire logic [ctc_pkg::COUNT_W-1:0]     cell_count,
	input wire logic [ctc_pkg::COUNT_W-1:0]     row_total,
	input wire logic [ctc_pkg::CFGS_W-1:0]      parent_configs,
	input wire logic [1:0]                      status
);
	import ctc_pkg::*;

	// a rejected item reports zero counts
	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == ST_RANGE) |-> (cell_count == '0 && row_total == '0))
		else $error("rejected result carries a count");

	// the configuration product lies between one and the table size
	a_cfgs_span: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (parent_configs != '0 && parent_configs <= CFGS_W'(TABLE_CELLS)))
		else $error("parent_configs out of span");

	// status is never the unused code
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> status != 2'd3)
		else $error("unused status code");

	// a waiting result holds until transferred
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(cell_count) && $stable(row_total)
			&& $stable(status)))
		else $error("waiting result changed");

endmodule

bind contingency_table_counter ctc_checker u_ctc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.pop            (pop),
	.empty          (empty),
	.cell_count     (cell_count),
	.row_total      (row_total),
	.parent_configs (parent_configs),
	.status         (status)
);
`default_nettype wire
